// ===== design/arspec_pkg.sv =====
// Shared types, codes and constant tables of the AR/ARMA spectrum evaluator.
// No dependencies; every other design file but arspec_ram refers to this package by scope.
`timescale 1ns / 1ps

package arspec_pkg;

    // Model size and angle grid
    localparam int ORDER_DEF = 16;
    localparam int NBINS     = 2048;
    localparam int QUARTER   = NBINS / 4;
    localparam int IDX_W     = $clog2(NBINS);
    localparam int ROM_AW    = $clog2(QUARTER + 1);

    // Request function codes
    localparam logic [1:0] FUNC_COEF  = 2'd0;
    localparam logic [1:0] FUNC_NOISE = 2'd1;
    localparam logic [1:0] FUNC_EVAL  = 2'd2;

    // Multiplier operation codes, issued in this order
    localparam logic [3:0] OP_SS   = 4'd0;
    localparam logic [3:0] OP_CC   = 4'd1;
    localparam logic [3:0] OP_DD   = 4'd2;
    localparam logic [3:0] OP_AA   = 4'd3;
    localparam logic [3:0] OP_BB   = 4'd4;
    localparam logic [3:0] OP_LL   = 4'd5;
    localparam logic [3:0] OP_LH   = 4'd6;
    localparam logic [3:0] OP_HL   = 4'd7;
    localparam logic [3:0] OP_HH   = 4'd8;
    localparam logic [3:0] OP_LAST = OP_HH;

    localparam logic [31:0] SAT_POWER = 32'hFFFF_FFFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         coef_index;
        logic [10:0]        bin;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [31:0] power;
        logic        saturated;
    } res_t;

    typedef struct packed {
        logic       arma;
        logic       load_coef;
        logic       load_noise;
        logic       clear;
        logic       issue;
        logic       round;
        logic       mul_en;
        logic [3:0] mul_op;
        logic       setup;
        logic       check;
        logic       div_step;
        logic       emit;
    } cmd_t;

    typedef logic [15:0] rom_t [QUARTER + 1];

    // Quarter-wave cosine in Q1.15 from a Q30 Taylor series
    function automatic rom_t build_rom();
        rom_t               r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int i = 0; i <= QUARTER; i++) begin
            x    = (HALF_PI_Q30 * 64'(i) + 64'(QUARTER / 2)) / 64'(QUARTER);
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 <<< 30;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 64'sd0;
            v = ($unsigned(sum) + (64'd1 << 14)) >> 15;
            if (v > 64'd32768)
                v = 64'd32768;
            r[i] = v[15:0];
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

endpackage

// ===== design/arspec_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module arspec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered reads
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/arspec_ctrl.sv =====
// Controller of the spectrum evaluator: request decode, mode register and sequencing.
// Depends on arspec_pkg.
`timescale 1ns / 1ps

module arspec_ctrl #(
    parameter int ORDER = arspec_pkg::ORDER_DEF,
    localparam int JW = $clog2(ORDER)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              ovf,
    output logic              busy,
    output logic [JW-1:0]     j,
    output arspec_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAC    = 4'd1;
    localparam logic [3:0] S_MDRAIN = 4'd2;
    localparam logic [3:0] S_ROUND  = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_SQW    = 4'd5;
    localparam logic [3:0] S_SETUP  = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    localparam logic [JW-1:0] LAST_AR   = JW'(ORDER - 1);
    localparam logic [JW-1:0] LAST_ARMA = JW'(ORDER / 2 - 1);

    logic [3:0]    state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          mode_reg;
    logic          take;
    logic [JW-1:0] j_last;

    assign take   = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign j      = j_reg;
    assign j_last = mode_reg ? LAST_ARMA : LAST_AR;

    // Hold the mode register; the user writes it only while idle, which the block leaves unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance the sequence and issue datapath commands
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.arma       = mode_reg;
        cmd.load_coef  = take && (func == arspec_pkg::FUNC_COEF);
        cmd.load_noise = take && (func == arspec_pkg::FUNC_NOISE);
        cmd.mul_op     = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE: begin
                if (take && (func == arspec_pkg::FUNC_EVAL)) begin
                    cmd.clear  = 1'b1;
                    j_next     = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                cmd.issue = 1'b1;
                if (j_reg == j_last) begin
                    cnt_next   = '0;
                    state_next = S_MDRAIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_MDRAIN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd1)
                    state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.round  = 1'b1;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg[3:0] == arspec_pkg::OP_LAST)
                    state_next = S_SQW;
            end
            S_SQW: begin
                state_next = S_SETUP;
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                cnt_next  = '0;
                if (ovf)
                    state_next = S_EMIT;
                else
                    state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == 6'd31)
                    state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/arspec_dp.sv =====
// Datapath of the spectrum evaluator: coefficient store, angle walk, MAC,
// shared 32x32 multiplier, and a bit-serial 32-bit quotient divider.
// Depends on arspec_pkg and arspec_ram.
`timescale 1ns / 1ps

module arspec_dp #(
    parameter int ORDER = arspec_pkg::ORDER_DEF,
    localparam int JW = $clog2(ORDER)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arspec_pkg::cmd_t cmd,
    input  logic [JW-1:0]    j,
    input  arspec_pkg::req_t req,
    output logic             ovf,
    output logic             done,
    output arspec_pkg::res_t res
);

    localparam int IW = arspec_pkg::IDX_W;
    localparam int RW = arspec_pkg::ROM_AW;
    localparam logic [IW:0] N_W  = (IW+1)'(arspec_pkg::NBINS);
    localparam logic [IW:0] Q1_W = (IW+1)'(arspec_pkg::QUARTER);
    localparam logic [IW:0] Q2_W = (IW+1)'(2 * arspec_pkg::QUARTER);
    localparam logic [IW:0] Q3_W = (IW+1)'(3 * arspec_pkg::QUARTER);
    localparam logic signed [63:0] ONE_Q42 = 64'sd1 <<< 42;
    localparam logic signed [63:0] HALF_Q22 = 64'sd1 <<< 21;

    function automatic logic [31:0] q20_mag(input logic signed [63:0] acc);
        logic signed [63:0] t;
        t = (acc + HALF_Q22) >>> 22;
        return t[63] ? 32'(-t) : t[31:0];
    endfunction

    // Coefficient store with per-slot valid bits (unwritten slots read as zero)
    logic             coef_we;
    logic [JW-1:0]    raddr_b;
    logic [31:0]      rd_a, rd_b;
    logic [ORDER-1:0] valid_reg;
    logic             vld_a_reg, vld_b_reg;

    assign coef_we = cmd.load_coef && (32'(req.coef_index) < ORDER);
    assign raddr_b = j + JW'(ORDER / 2);

    arspec_ram #(
        .WIDTH (32),
        .DEPTH (ORDER)
    ) u_coef_ram (
        .clk     (clk),
        .we      (coef_we),
        .waddr   (JW'(req.coef_index)),
        .wdata   (req.value),
        .raddr_a (j),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (coef_we)
            valid_reg[JW'(req.coef_index)] <= 1'b1;
    end

    // Noise level, negative values stored as zero
    logic [30:0] sig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sig_reg <= '0;
        else if (cmd.load_noise)
            sig_reg <= req.value[31] ? 31'd0 : req.value[30:0];
    end

    // Walk the angle index by k each step, wrapped to the bin count
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] k_reg;
    logic [IW:0]   idx_sum;
    logic [IW:0]   k_ext;

    assign k_ext   = (IW+1)'(req.bin);
    assign idx_sum = {1'b0, idx_reg} + {1'b0, k_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.clear) begin
            k_reg   <= IW'((k_ext >= N_W) ? k_ext - N_W : k_ext);
            idx_reg <= IW'((k_ext >= N_W) ? k_ext - N_W : k_ext);
        end else if (cmd.issue) begin
            idx_reg <= IW'((idx_sum >= N_W) ? idx_sum - N_W : idx_sum);
        end
    end

    // Fold the angle onto the quarter wave
    logic [IW:0] idx_w, ca_w, sa_w;
    logic        cneg, sneg;

    assign idx_w = {1'b0, idx_reg};

    always_comb
    begin
        if (idx_w < Q1_W) begin
            ca_w = idx_w;        cneg = 1'b0;
            sa_w = Q1_W - idx_w; sneg = 1'b0;
        end else if (idx_w < Q2_W) begin
            ca_w = Q2_W - idx_w; cneg = 1'b1;
            sa_w = idx_w - Q1_W; sneg = 1'b0;
        end else if (idx_w < Q3_W) begin
            ca_w = idx_w - Q2_W; cneg = 1'b1;
            sa_w = Q3_W - idx_w; sneg = 1'b1;
        end else begin
            ca_w = N_W - idx_w;  cneg = 1'b0;
            sa_w = idx_w - Q3_W; sneg = 1'b1;
        end
    end

    // MAC stage 1: registered table and store reads
    logic [15:0] cmag_reg, smag_reg;
    logic        cneg_reg, sneg_reg;
    logic        v1_reg, v2_reg;

    always_ff @(posedge clk)
    begin
        cmag_reg  <= arspec_pkg::COS_ROM[RW'(ca_w)];
        smag_reg  <= arspec_pkg::COS_ROM[RW'(sa_w)];
        cneg_reg  <= cneg;
        sneg_reg  <= sneg;
        vld_a_reg <= valid_reg[j];
        vld_b_reg <= valid_reg[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // MAC stage 2: signed products
    logic signed [16:0] cs, sn;
    logic signed [31:0] coef0, coef1;
    logic signed [48:0] p0c_reg, p0s_reg, p1c_reg, p1s_reg;

    assign cs    = cneg_reg ? -$signed({1'b0, cmag_reg}) : $signed({1'b0, cmag_reg});
    assign sn    = sneg_reg ? -$signed({1'b0, smag_reg}) : $signed({1'b0, smag_reg});
    assign coef0 = vld_a_reg ? $signed(rd_a) : 32'sd0;
    assign coef1 = vld_b_reg ? $signed(rd_b) : 32'sd0;

    always_ff @(posedge clk)
    begin
        p0c_reg <= coef0 * cs;
        p0s_reg <= coef0 * sn;
        p1c_reg <= coef1 * cs;
        p1s_reg <= coef1 * sn;
    end

    // MAC stage 3: accumulate in Q.42
    logic signed [63:0] a_reg, b_reg, c_reg, d_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear) begin
            a_reg <= ONE_Q42;
            b_reg <= '0;
            c_reg <= ONE_Q42;
            d_reg <= '0;
        end else if (v2_reg) begin
            if (cmd.arma) begin
                a_reg <= a_reg + 64'(p0c_reg);
                b_reg <= b_reg + 64'(p0s_reg);
                c_reg <= c_reg + 64'(p1c_reg);
                d_reg <= d_reg + 64'(p1s_reg);
            end else begin
                c_reg <= c_reg + 64'(p0c_reg);
                d_reg <= d_reg + 64'(p0s_reg);
            end
        end
    end

    // Round to Q.20 and keep magnitudes
    logic [31:0] ma_reg, mb_reg, mc_reg, md_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.round) begin
            ma_reg <= q20_mag(a_reg);
            mb_reg <= q20_mag(b_reg);
            mc_reg <= q20_mag(c_reg);
            md_reg <= q20_mag(d_reg);
        end
    end

    // Shared multiplier: operand select, registered product, then accumulate
    logic [63:0]  s2_reg, p_reg, m_reg, x_op;
    logic [127:0] w_reg;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod_reg;
    logic [3:0]   op_reg;
    logic         mv_reg;

    assign x_op = cmd.arma ? s2_reg : p_reg;

    always_comb
    begin
        case (cmd.mul_op)
            arspec_pkg::OP_SS: begin mul_a = {1'b0, sig_reg}; mul_b = {1'b0, sig_reg}; end
            arspec_pkg::OP_CC: begin mul_a = mc_reg;          mul_b = mc_reg;          end
            arspec_pkg::OP_DD: begin mul_a = md_reg;          mul_b = md_reg;          end
            arspec_pkg::OP_AA: begin mul_a = ma_reg;          mul_b = ma_reg;          end
            arspec_pkg::OP_BB: begin mul_a = mb_reg;          mul_b = mb_reg;          end
            arspec_pkg::OP_LL: begin mul_a = x_op[31:0];      mul_b = p_reg[31:0];     end
            arspec_pkg::OP_LH: begin mul_a = x_op[31:0];      mul_b = p_reg[63:32];    end
            arspec_pkg::OP_HL: begin mul_a = x_op[63:32];     mul_b = p_reg[31:0];     end
            arspec_pkg::OP_HH: begin mul_a = x_op[63:32];     mul_b = p_reg[63:32];    end
            default:           begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        op_reg   <= cmd.mul_op;
        if (mv_reg) begin
            case (op_reg)
                arspec_pkg::OP_SS: s2_reg <= prod_reg;
                arspec_pkg::OP_CC: p_reg  <= prod_reg;
                arspec_pkg::OP_DD: p_reg  <= p_reg + prod_reg;
                arspec_pkg::OP_AA: m_reg  <= prod_reg;
                arspec_pkg::OP_BB: m_reg  <= m_reg + prod_reg;
                arspec_pkg::OP_LL: w_reg  <= {64'd0, prod_reg};
                arspec_pkg::OP_LH,
                arspec_pkg::OP_HL: w_reg  <= w_reg + {32'd0, prod_reg, 32'd0};
                arspec_pkg::OP_HH: w_reg  <= w_reg + {prod_reg, 64'd0};
                default: ;
            endcase
        end
    end

    // Division: saturate when the quotient cannot fit or, in ARMA mode, when
    // the C,D power is zero; else one bit a cycle
    logic [127:0] num_reg, den_reg, rem_reg;
    logic [159:0] dsh_reg;
    logic [31:0]  q_reg;
    logic         sat_reg;
    logic         ge;

    assign ovf = ({32'd0, num_reg} >= {den_reg, 32'd0}) ||
                 (cmd.arma && (p_reg == 64'd0));
    assign ge  = {32'd0, rem_reg} >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup) begin
            num_reg <= cmd.arma ? w_reg : {s2_reg, 64'd0};
            den_reg <= cmd.arma ? {48'd0, m_reg, 16'd0} : w_reg;
        end
        if (cmd.check) begin
            sat_reg <= ovf;
            rem_reg <= num_reg;
            dsh_reg <= {1'b0, den_reg, 31'd0};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg[127:0];
            q_reg   <= {q_reg[30:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Present the result for one cycle
    logic done_reg;
    arspec_pkg::res_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            res_reg.power     <= sat_reg ? arspec_pkg::SAT_POWER : q_reg;
            res_reg.saturated <= sat_reg;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== design/ar_arma_spectrum_evaluator.sv =====
// Top level of the AR/ARMA power spectral density evaluator.
// Depends on arspec_pkg, arspec_ctrl and arspec_dp.
`timescale 1ns / 1ps

// Load requests (coefficient or noise level) complete when taken and leave busy low.
// An evaluate request runs from acceptance to the done strobe through the coefficient
// MAC walk over n coefficients (n = ORDER in AR mode, ORDER/2 in ARMA mode), nine
// passes through the one shared 32x32 multiplier, and a 32-step bit-serial divider,
// which is skipped when the result saturates.
// The result is shown for exactly one cycle with done high and cannot be held
// off; a new request is taken in that same cycle. The user must write the mode register
// through cfg_valid/cfg_data only while busy is low (left unchecked); it is always ready.
module ar_arma_spectrum_evaluator #(
    parameter int ORDER = arspec_pkg::ORDER_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  arspec_pkg::req_t req,
    output logic             done,
    output arspec_pkg::res_t res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);

    localparam int JW = $clog2(ORDER);

    arspec_pkg::cmd_t cmd;
    logic [JW-1:0]    j;
    logic             ovf;

    assign cfg_ready = 1'b1;

    arspec_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (req.func),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ovf       (ovf),
        .busy      (busy),
        .j         (j),
        .cmd       (cmd)
    );

    arspec_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .j     (j),
        .req   (req),
        .ovf   (ovf),
        .done  (done),
        .res   (res)
    );

endmodule

// ===== design/arspec_checker.sv =====
// Port-level checks of the spectrum evaluator, bound to the top level.
// Depends on arspec_pkg and ar_arma_spectrum_evaluator.
`timescale 1ns / 1ps

module arspec_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input arspec_pkg::req_t req,
    input logic             done,
    input arspec_pkg::res_t res
);

    // A result arrives with the block free for the next request
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An evaluate request occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.func == arspec_pkg::FUNC_EVAL) |=> busy)
        else $error("evaluate request did not start work");

    // Other requests complete at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.func != arspec_pkg::FUNC_EVAL) |=> !busy)
        else $error("load request held the block");

    // Strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe repeated");

    // Saturation forces full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.saturated) |-> (res.power == arspec_pkg::SAT_POWER))
        else $error("saturated result not at full scale");

endmodule

bind ar_arma_spectrum_evaluator arspec_checker u_arspec_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
);
